// ----- rtl/wsd_pkg.sv -----
// Package for the WebSocket frame deframer: length constants, parse phase enum
// and the result record shared by the parser and the top level. No dependencies.
package wsd_pkg;

	localparam int LENGTH_BITS = 63;
	localparam int LEN_W       = 63;

	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR1  = 3'd0,
		PH_HDR2  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_KEY   = 3'd4,
		PH_PAY   = 3'd5
	} phase_t;

	typedef struct packed {
		logic             valid;
		logic [7:0]       payload_byte;
		logic             payload_valid;
		logic [3:0]       opcode;
		logic             final_fragment;
		logic [2:0]       reserved_bits;
		logic             was_masked;
		logic [LEN_W-1:0] frame_length;
		logic             frame_end;
	} result_t;

endpackage

// ----- rtl/wsd_if.sv -----
// Valid/ready channel interfaces of the deframer: the raw byte stream and the
// deframed result stream. Depends on wsd_pkg.
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_frame_if;
	logic                      valid;
	logic                      ready;
	logic [7:0]                payload_byte;
	logic                      payload_valid;
	logic [3:0]                opcode;
	logic                      final_fragment;
	logic [2:0]                reserved_bits;
	logic                      was_masked;
	logic [wsd_pkg::LEN_W-1:0] frame_length;
	logic                      frame_end;

	modport source (output valid, output payload_byte, output payload_valid, output opcode,
		output final_fragment, output reserved_bits, output was_masked,
		output frame_length, output frame_end, input ready);
	modport sink (input valid, input payload_byte, input payload_valid, input opcode,
		input final_fragment, input reserved_bits, input was_masked,
		input frame_length, input frame_end, output ready);
endinterface

// ----- rtl/wsd_parser.sv -----
// Frame header parser and payload unmasker: holds the parse state and turns one
// stream byte per step into at most one result. Depends on wsd_pkg.
module wsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data,
	output wsd_pkg::result_t res
);

	wsd_pkg::phase_t            phase_q, phase_d;
	logic [2:0]                 cnt_q;
	logic                       fin_q;
	logic [2:0]                 rsv_q;
	logic [3:0]                 opc_q;
	logic                       mask_q;
	logic [31:0]                key_q;
	logic [wsd_pkg::LEN_W-1:0]  len_q;
	logic [wsd_pkg::LEN_W-1:0]  rem_q;
	logic [1:0]                 kpos_q;

	logic [6:0]                 code;
	logic                       code_ext;
	logic [wsd_pkg::LEN_W-1:0]  len_shift, len_sat, len_nxt;
	logic                       mask_nxt;
	logic                       ext_last, key_last, hdr_done, len_zero, rem_last;
	logic [7:0]                 kb;

	assign code      = data[6:0];
	assign code_ext  = (code == wsd_pkg::LEN_CODE_EXT16) || (code == wsd_pkg::LEN_CODE_EXT64);
	assign len_shift = {len_q[wsd_pkg::LEN_W-9:0], data};
	assign len_sat   = (len_shift > wsd_pkg::LEN_LIMIT) ? wsd_pkg::LEN_LIMIT : len_shift;
	assign ext_last  = ((phase_q == wsd_pkg::PH_EXT16) && (cnt_q == 3'd1)) ||
		((phase_q == wsd_pkg::PH_EXT64) && (cnt_q == 3'd7));
	assign key_last  = (cnt_q == 3'd3);
	assign mask_nxt  = (phase_q == wsd_pkg::PH_HDR2) ? data[7] : mask_q;
	assign rem_last  = (rem_q == wsd_pkg::LEN_W'(1));

	always_comb begin
		case (phase_q)
			wsd_pkg::PH_HDR2: begin
				len_nxt = code_ext ? '0 : wsd_pkg::LEN_W'(code);
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				len_nxt = len_sat;
			end
			default: begin
				len_nxt = len_q;
			end
		endcase
	end

	assign len_zero = (len_nxt == '0);

	// header finishes on this byte (length and key, if any, all seen)
	always_comb begin
		case (phase_q)
			wsd_pkg::PH_HDR2:                     hdr_done = !code_ext && !data[7];
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: hdr_done = ext_last && !mask_q;
			wsd_pkg::PH_KEY:                      hdr_done = key_last;
			default:                              hdr_done = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		case (phase_q)
			wsd_pkg::PH_HDR1: begin
				phase_d = wsd_pkg::PH_HDR2;
			end
			wsd_pkg::PH_HDR2: begin
				if (code == wsd_pkg::LEN_CODE_EXT16) begin
					phase_d = wsd_pkg::PH_EXT16;
				end else if (code == wsd_pkg::LEN_CODE_EXT64) begin
					phase_d = wsd_pkg::PH_EXT64;
				end else if (data[7]) begin
					phase_d = wsd_pkg::PH_KEY;
				end else begin
					phase_d = len_zero ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_PAY;
				end
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				if (!ext_last) begin
					phase_d = phase_q;
				end else if (mask_q) begin
					phase_d = wsd_pkg::PH_KEY;
				end else begin
					phase_d = len_zero ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_PAY;
				end
			end
			wsd_pkg::PH_KEY: begin
				if (!key_last) begin
					phase_d = wsd_pkg::PH_KEY;
				end else begin
					phase_d = len_zero ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_PAY;
				end
			end
			wsd_pkg::PH_PAY: begin
				phase_d = rem_last ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_PAY;
			end
			default: begin
				phase_d = wsd_pkg::PH_HDR2;
			end
		endcase
	end

	// key byte for this payload position, first key byte in the top bits
	always_comb begin
		case (kpos_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
	end

	// outputs
	always_comb begin
		res                = '0;
		res.opcode         = opc_q;
		res.final_fragment = fin_q;
		res.reserved_bits  = rsv_q;
		res.was_masked     = mask_nxt;
		res.frame_length   = len_nxt;
		if (step && (phase_q == wsd_pkg::PH_PAY)) begin
			res.valid         = 1'b1;
			res.payload_valid = 1'b1;
			res.payload_byte  = data ^ (mask_q ? kb : 8'h00);
			res.frame_end     = rem_last;
		end else if (step && hdr_done && len_zero) begin
			res.valid     = 1'b1;
			res.frame_end = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_HDR1;
			cnt_q   <= '0;
			kpos_q  <= '0;
			fin_q   <= 1'b0;
			rsv_q   <= '0;
			opc_q   <= '0;
			mask_q  <= 1'b0;
			key_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				wsd_pkg::PH_HDR2: begin
					mask_q <= data[7];
					len_q  <= len_nxt;
					cnt_q  <= '0;
					key_q  <= '0;
				end
				wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
					len_q <= len_nxt;
					cnt_q <= ext_last ? 3'd0 : cnt_q + 3'd1;
				end
				wsd_pkg::PH_KEY: begin
					key_q <= {key_q[23:0], data};
					cnt_q <= key_last ? 3'd0 : cnt_q + 3'd1;
				end
				wsd_pkg::PH_PAY: begin
					kpos_q <= kpos_q + 2'd1;
					rem_q  <= rem_q - wsd_pkg::LEN_W'(1);
				end
				default: begin
					fin_q  <= data[7];
					rsv_q  <= data[6:4];
					opc_q  <= data[3:0];
					mask_q <= 1'b0;
				end
			endcase
			if (hdr_done) begin
				rem_q  <= len_nxt;
				kpos_q <= '0;
			end
		end
	end

	a_pay_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsd_pkg::PH_PAY |-> rem_q != '0)
		else $error("payload phase with no bytes remaining");

	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> step)
		else $error("result without a byte");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_end |=> phase_q == wsd_pkg::PH_HDR1)
		else $error("frame end did not return to header parsing");

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// WebSocket frame deframer top level: input byte register, header parser and
// result register. Depends on wsd_pkg, wsd_if and wsd_parser.
// Takes one stream byte per clock while the result side keeps taking beats, and
// gives at most one result per byte: each payload byte unmasked and tagged with
// its frame's header fields, or a single empty result for a zero-length frame.
// A byte moves from the input register through the parser into the result
// register. Header bytes give no result, but for the last header byte of a
// zero-length frame.
module websocket_frame_deframer (
	input  logic               clk,
	input  logic               arst_n,
	wsd_byte_if.sink           stream,
	wsd_frame_if.source        deframed
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	wsd_pkg::result_t res;
	wsd_pkg::result_t out_q;
	logic             out_valid_q;

	assign advance      = valid_s1 && (!out_valid_q || deframed.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.in_byte;
		end
	end

	wsd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (deframed.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign deframed.valid          = out_valid_q;
	assign deframed.payload_byte   = out_q.payload_byte;
	assign deframed.payload_valid  = out_q.payload_valid;
	assign deframed.opcode         = out_q.opcode;
	assign deframed.final_fragment = out_q.final_fragment;
	assign deframed.reserved_bits  = out_q.reserved_bits;
	assign deframed.was_masked     = out_q.was_masked;
	assign deframed.frame_length   = out_q.frame_length;
	assign deframed.frame_end      = out_q.frame_end;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input beat lost");

	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> deframed.valid)
		else $error("parser result not registered");

	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		deframed.valid && !deframed.payload_valid |->
			deframed.frame_end && (deframed.payload_byte == 8'h00))
		else $error("malformed empty-frame result");

endmodule
